### hw/rtl/pba_pkg.sv
// Package for the packed bit-field array: sizes, opcodes, store interface types
// and the element width clamp. No dependencies.
package pba_pkg;

   localparam int STORE_BYTES = 4096;
   localparam int MAX_WIDTH   = 24;

   localparam int CFG_W  = 5;
   localparam int POS_W  = 15;
   localparam int VAL_W  = 24;

   localparam int STORE_BITS = STORE_BYTES * 8;
   localparam int WORD_W     = 32;
   localparam int WORDS      = STORE_BYTES / 4;
   localparam int BANK_DEPTH = WORDS / 2;
   localparam int WIDX_W     = $clog2(WORDS);
   localparam int BANK_AW    = $clog2(BANK_DEPTH);
   localparam int BOFF_W     = $clog2(WORD_W);
   localparam int WIN_W      = 2 * WORD_W;
   localparam int SH_W       = $clog2(WIN_W);
   localparam int OFF_W      = POS_W + CFG_W;
   localparam int END_W      = OFF_W + 1;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [WIDX_W-1:0] word_idx;
      logic [WIN_W-1:0]  wr_window;
   } store_req_type;

   typedef struct packed {
      logic             ready;
      logic [WIN_W-1:0] rd_window;
   } store_rsp_type;

   function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] cfg);
      logic [CFG_W-1:0] w;
      w = cfg;
      if (w == '0)
         w = CFG_W'(1);
      if (w > CFG_W'(MAX_WIDTH))
         w = CFG_W'(MAX_WIDTH);
      return w;
   endfunction

endpackage

### hw/rtl/pba_ram.sv
// Single-port synchronous RAM, registered read data.
// Generic; no dependencies.
module pba_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic             re,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we)
         mem[addr] <= wdata;
      if (re)
         rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/pba_store.sv
// Word store: two 32-bit banks (even and odd words) so a 64-bit window of
// adjacent words is read or written in one access; clearing sweep after reset.
// Depends on pba_pkg and pba_ram.
module pba_store (
   input  logic                   clock,
   input  logic                   reset,
   input  pba_pkg::store_req_type req,
   output pba_pkg::store_rsp_type rsp
);
   import pba_pkg::*;

   logic [BANK_AW:0]   clr_cnt_ff, clr_cnt_in;
   logic               sel_ff, sel_in;
   logic               clearing;
   logic [BANK_AW-1:0] row_lo, even_addr, odd_addr;
   logic [WORD_W-1:0]  even_wdata, odd_wdata, even_rdata, odd_rdata;
   logic [WORD_W-1:0]  word_a, word_b;
   logic               we, re;

   assign clearing = clr_cnt_ff != (BANK_AW+1)'(BANK_DEPTH);
   assign clr_cnt_in = clearing ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
   assign sel_in = req.rd_en ? req.word_idx[0] : sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
      sel_ff <= sel_in;
   end

   assign row_lo = req.word_idx[WIDX_W-1:1];
   assign word_a = req.wr_window[WIN_W-1:WORD_W];
   assign word_b = req.wr_window[WORD_W-1:0];

   always_comb begin
      if (clearing) begin
         even_addr  = clr_cnt_ff[BANK_AW-1:0];
         odd_addr   = clr_cnt_ff[BANK_AW-1:0];
         even_wdata = '0;
         odd_wdata  = '0;
         we         = 1'b1;
         re         = 1'b0;
      end else begin
         odd_addr   = row_lo;
         even_addr  = row_lo + BANK_AW'(req.word_idx[0]);
         even_wdata = req.word_idx[0] ? word_b : word_a;
         odd_wdata  = req.word_idx[0] ? word_a : word_b;
         we         = req.wr_en;
         re         = req.rd_en;
      end
   end

   pba_ram #(.DEPTH(BANK_DEPTH), .WIDTH(WORD_W)) u_even (
      .clock (clock),
      .we    (we),
      .re    (re),
      .addr  (even_addr),
      .wdata (even_wdata),
      .rdata (even_rdata)
   );

   pba_ram #(.DEPTH(BANK_DEPTH), .WIDTH(WORD_W)) u_odd (
      .clock (clock),
      .we    (we),
      .re    (re),
      .addr  (odd_addr),
      .wdata (odd_wdata),
      .rdata (odd_rdata)
   );

   assign rsp.ready     = !clearing;
   assign rsp.rd_window = sel_ff ? {odd_rdata, even_rdata} : {even_rdata, odd_rdata};

endmodule

### hw/rtl/packed_bitfield_array.sv
// Packed bit-field array, top level: control sequencer, field extract/insert
// and result register. Depends on pba_pkg and pba_store.
//
// Usage:
//   req_* carries one item: tuser = opcode (0 read, 1 write), tdata = position
//   and write value. rsp_* returns one item per request: tdata = read value,
//   tuser = range error. csr_* writes the element width (clamped to 1..24);
//   write it only while no item is in flight.
//   Element p covers bits p*w .. p*w+w-1 of the store, MSB first. A position
//   running past the 32768-bit store gives range error; writes are dropped and
//   reads return zero.
// Sequence:
//   rsp_tvalid rises once an accepted item has passed ST_CALC (width multiply
//   and range check), ST_READ (one read of two adjacent 32-bit words from the
//   even/odd banks), then ST_MOD (modify with write-back). One item is in
//   flight at a time and req_tready returns with the result, so the block takes
//   no new item until the read-modify-write on the store banks is through.
// Reset:
//   Reset clears the element width to 8 and starts a sweep zeroing the store;
//   req_tready stays low until it finishes. CSR writes are taken.
// Stall:
//   A result held by rsp_tready low occupies the output register; the block
//   finishes the next item into a hold stage and then waits for the receiver.
module packed_bitfield_array (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [39:0]                 req_tdata,   // position[14:0], write_value[38:15]
   input  logic                        req_tuser,   // opcode
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata,   // read_value[23:0]
   output logic                        rsp_tuser,   // range_error
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [pba_pkg::CFG_W-1:0]   csr_data
);
   import pba_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CALC = 5'b00010,
      ST_READ = 5'b00100,
      ST_MOD  = 5'b01000,
      ST_HOLD = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  cfg_ff, cfg_in;
   logic              op_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [VAL_W-1:0]  wval_ff;
   logic [CFG_W-1:0]  w_ff;
   logic [OFF_W-1:0]  off_ff;
   logic              err_ff;
   logic [SH_W-1:0]   sh_ff;
   logic [VAL_W-1:0]  mask_ff;
   logic [VAL_W-1:0]  res_val_ff;
   logic              res_err_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]  rsp_val_ff;
   logic              rsp_err_ff;

   logic [OFF_W-1:0]  prod;
   logic [END_W-1:0]  end_bit;
   logic [SH_W:0]     sh_full;
   logic [VAL_W:0]    one_shl;
   logic [WIN_W-1:0]  win_mask, win_bits, new_win, shifted;
   logic [VAL_W-1:0]  ext_val, res_val;
   logic              accept, out_free, load_out;

   store_req_type     st_req;
   store_rsp_type     st_rsp;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE) && st_rsp.ready;
   assign csr_ready  = 1'b1;
   assign cfg_in     = csr_valid ? csr_data : cfg_ff;

   // offset and range check
   assign prod    = OFF_W'(pos_ff) * OFF_W'(w_ff);
   assign end_bit = END_W'(prod) + END_W'(w_ff);

   // shift and mask setup
   assign sh_full = (SH_W+1)'(WIN_W) - (SH_W+1)'(off_ff[BOFF_W-1:0]) - (SH_W+1)'(w_ff);
   assign one_shl = (VAL_W+1)'(1) << w_ff;

   // extract / insert on the two-word window
   assign win_mask = WIN_W'(mask_ff) << sh_ff;
   assign win_bits = WIN_W'(wval_ff & mask_ff) << sh_ff;
   assign new_win  = (st_rsp.rd_window & ~win_mask) | win_bits;
   assign shifted  = st_rsp.rd_window >> sh_ff;
   assign ext_val  = shifted[VAL_W-1:0] & mask_ff;
   assign res_val  = (err_ff || op_ff == OP_WRITE) ? '0 : ext_val;

   assign st_req.rd_en     = (state_ff == ST_READ) && !err_ff;
   assign st_req.wr_en     = (state_ff == ST_MOD) && !err_ff && (op_ff == OP_WRITE);
   assign st_req.word_idx  = off_ff[BOFF_W +: WIDX_W];
   assign st_req.wr_window = new_win;

   always_comb begin
      state_in = state_ff;
      load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept)
               state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_MOD;
         end
         ST_MOD: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = load_out ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= CFG_W'(8);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_tuser;
         pos_ff  <= req_tdata[POS_W-1:0];
         wval_ff <= req_tdata[POS_W +: VAL_W];
         w_ff    <= eff_width(cfg_ff);
      end
      if (state_ff == ST_CALC) begin
         off_ff <= prod;
         err_ff <= end_bit > END_W'(STORE_BITS);
      end
      if (state_ff == ST_READ) begin
         sh_ff   <= sh_full[SH_W-1:0];
         mask_ff <= VAL_W'(one_shl - 1'b1);
      end
      if (state_ff == ST_MOD) begin
         res_val_ff <= res_val;
         res_err_ff <= err_ff;
      end
      if (load_out) begin
         rsp_val_ff <= (state_ff == ST_HOLD) ? res_val_ff : res_val;
         rsp_err_ff <= (state_ff == ST_HOLD) ? res_err_ff : err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_val_ff;
   assign rsp_tuser  = rsp_err_ff;

   pba_store u_store (
      .clock (clock),
      .reset (reset),
      .req   (st_req),
      .rsp   (st_rsp)
   );

endmodule

### tb/testbench.sv
// Self-checking testbench for packed_bitfield_array: read/write items against a
// shadow byte store, several element widths and handshake idle patterns.
// Depends on pba_pkg and the packed_bitfield_array RTL.
`timescale 1ns / 100ps

module testbench;
   import pba_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int MAX_PRINTS     = 30;

   typedef struct {
      logic             op;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] value;
   } element_op_type;

   typedef struct packed {
      logic [VAL_W-1:0] read_value;
      logic             range_error;
   } element_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [39:0]        req_tdata = '0;    // position[14:0], write_value[38:15]
   logic               req_tuser = 1'b0;  // opcode
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [23:0]        rsp_tdata;         // read_value[23:0]
   logic               rsp_tuser;         // range_error
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CFG_W-1:0]   csr_data = '0;

   element_op_type     element_ops[$];
   element_rsp_type    predicted_rsps[$];
   logic [7:0]         shadow_bytes[STORE_BYTES];
   logic [CFG_W-1:0]   shadow_width = CFG_W'(8);

   logic               req_done = 1'b0;
   int                 req_idle_pct = 0;
   int                 rsp_stall_pct = 0;
   int                 error_count = 0;
   int                 read_count = 0;
   int                 write_count = 0;
   int                 range_count = 0;
   int                 width_writes = 0;
   int                 idle_cycles = 0;

   packed_bitfield_array u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned bits_per_element(input logic [CFG_W-1:0] cfg);
      if (cfg == '0)
         return 1;
      if (cfg > CFG_W'(MAX_WIDTH))
         return MAX_WIDTH;
      return 32'(cfg);
   endfunction

   // MSB-first bit addressing: array bit k is bit 7-(k%8) of byte k/8
   function automatic element_rsp_type access_element(input element_op_type it);
      element_rsp_type r;
      int unsigned     w;
      int unsigned     first;
      int unsigned     k;
      r = '0;
      w = bits_per_element(shadow_width);
      first = int'(it.pos) * w;
      if (first + w > STORE_BITS) begin
         r.range_error = 1'b1;
         return r;
      end
      for (int i = 0; i < w; i++) begin
         k = first + i;
         if (it.op == OP_WRITE)
            shadow_bytes[k >> 3][7 - (k & 7)] = it.value[w - 1 - i];
         else
            r.read_value = {r.read_value[VAL_W-2:0], shadow_bytes[k >> 3][7 - (k & 7)]};
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   // request driver
   always @(negedge clock) begin : drive_req
      element_op_type nxt;
      if (!req_tvalid || req_done) begin
         if (element_ops.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
            nxt = element_ops.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {1'b0, nxt.value, nxt.pos};
            req_tuser  <= nxt.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // monitor and checker
   always @(posedge clock) begin : observe
      element_op_type  seen;
      element_rsp_type want;
      req_done <= req_tvalid && req_tready;
      if (!reset) begin
         if (csr_valid && csr_ready)
            shadow_width = csr_data;
         if (req_tvalid && req_tready) begin
            seen.op    = req_tuser;
            seen.pos   = req_tdata[POS_W-1:0];
            seen.value = req_tdata[POS_W +: VAL_W];
            predicted_rsps.push_back(access_element(seen));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_rsps.size() == 0) begin
               report_mismatch("result item with nothing outstanding");
            end else begin
               want = predicted_rsps.pop_front();
               if (want.range_error)
                  range_count++;
               if (rsp_tdata !== want.read_value)
                  report_mismatch($sformatf("read_value %h, predicted %h",
                                            rsp_tdata, want.read_value));
               if (rsp_tuser !== want.range_error)
                  report_mismatch($sformatf("range_error %b, predicted %b",
                                            rsp_tuser, want.range_error));
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_op(input logic op, input int pos, input int value);
      element_op_type it;
      it.op    = op;
      it.pos   = POS_W'(pos);
      it.value = VAL_W'(value);
      element_ops.push_back(it);
      if (op == OP_WRITE)
         write_count++;
      else
         read_count++;
   endtask

   // checked at the rising edge, where req_tvalid and the queues are settled
   task automatic wait_idle();
      while (element_ops.size() > 0 || req_tvalid || predicted_rsps.size() > 0)
         @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_width(input logic [CFG_W-1:0] cfg);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= cfg;
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      width_writes++;
   endtask

   initial begin : stimulus
      logic [CFG_W-1:0] cfg;
      int unsigned      lim;
      int               hot_base;
      int               pos;
      int               sel;
      logic [CFG_W-1:0] extremes[4];
      int               idle_pct[4];
      int               stall_pct[4];
      extremes  = '{CFG_W'(24), CFG_W'(1), CFG_W'(31), CFG_W'(0)};
      idle_pct  = '{0, 45, 0, 34};
      stall_pct = '{0, 0, 45, 34};
      foreach (shadow_bytes[i])
         shadow_bytes[i] = 8'h00;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset width 8: masking, last in-range byte, just past the end
      queue_op(OP_WRITE, 0, 24'hFFFFFF);
      queue_op(OP_READ, 0, 0);
      queue_op(OP_WRITE, 4095, 24'h00005A);
      queue_op(OP_READ, 4095, 0);
      queue_op(OP_READ, 4096, 0);
      queue_op(OP_WRITE, 4096, 24'hFFFFFF);
      queue_op(OP_READ, 32767, 0);
      queue_op(OP_READ, 1, 0);
      // width zero acts as one bit
      set_width(CFG_W'(0));
      queue_op(OP_WRITE, 32767, 24'hFFFFFF);
      queue_op(OP_READ, 32767, 0);
      queue_op(OP_READ, 0, 0);
      queue_op(OP_READ, 7, 0);
      // width above the limit clamps to 24
      set_width(CFG_W'(31));
      queue_op(OP_WRITE, 1364, 24'hFFFFFF);
      queue_op(OP_READ, 1364, 0);
      queue_op(OP_READ, 1365, 0);
      queue_op(OP_WRITE, 1365, 24'hABCDEF);
      queue_op(OP_WRITE, 3, 24'h123456);
      queue_op(OP_READ, 3, 0);
      queue_op(OP_READ, 2, 0);

      for (int ph = 0; ph < 4; ph++) begin
         for (int sub = 0; sub < 4; sub++) begin
            cfg = (sub == 0) ? extremes[ph] : CFG_W'($urandom_range(31));
            set_width(cfg);
            req_idle_pct  = idle_pct[ph];
            rsp_stall_pct = stall_pct[ph];
            lim = STORE_BITS / bits_per_element(cfg);
            hot_base = $urandom_range(lim - 16);
            for (int n = 0; n < 50; n++) begin
               sel = $urandom_range(99);
               if (sel < 70)
                  pos = hot_base + $urandom_range(15);
               else if (sel < 85)
                  pos = $urandom_range(32767);
               else
                  pos = int'(lim) - 2 + $urandom_range(3);
               if (pos > 32767)
                  pos = 32767;
               queue_op(1'($urandom_range(1)), pos, $urandom_range(24'hFFFFFF));
            end
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (predicted_rsps.size() != 0)
         report_mismatch($sformatf("%0d result items never arrived", predicted_rsps.size()));
      $display("covered %0d reads, %0d writes (%0d out of range), %0d width settings",
               read_count, write_count, range_count, width_writes);
      $display("idle patterns: none, sender gaps, receiver stalls, both; %0d mismatches",
               error_count);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
